>>> rtl/bfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID     = 1'b1;

  localparam logic [7:0] START_MARKER_RST = 8'hFE;
  localparam logic [7:0] FRAME_ID_RST     = 8'h4D;
  localparam logic [7:0] EXT_LEN_CODE     = 8'hFF;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_ACCEPT   = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_OVERSIZE = 2'd3;

  typedef enum logic [3:0] {
    PH_SOF  = 4'd0,
    PH_LEN  = 4'd1,
    PH_ID   = 4'd2,
    PH_CMD  = 4'd3,
    PH_DATA = 4'd4,
    PH_FCS  = 4'd5,
    PH_XL1  = 4'd6,
    PH_XL2  = 4'd7,
    PH_XL3  = 4'd8,
    PH_XL4  = 4'd9
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [31:0] frame_length;
    logic        chunk_accepted;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/bfr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output operation, output data_byte, output chunk_end,
                  input ready);
  modport sink   (input valid, input operation, input data_byte, input chunk_end,
                  output ready);
endinterface

interface bfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  command;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [31:0] frame_length;
  logic        chunk_accepted;

  modport source (output valid, output status, output command, output payload_valid,
                  output payload_byte, output payload_index, output frame_length,
                  output chunk_accepted, input ready);
  modport sink   (input valid, input status, input command, input payload_valid,
                  input payload_byte, input payload_index, input frame_length,
                  input chunk_accepted, output ready);
endinterface

`default_nettype wire

>>> rtl/bfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module bfr_parser #(
  parameter int MAX_PAYLOAD = 255
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire bfr_pkg::in_item_t item,
  input  wire logic [7:0]       start_marker,
  input  wire logic [7:0]       expected_frame_id,
  output bfr_pkg::result_t      res
);
  import bfr_pkg::*;

  localparam logic [7:0] MaxCount = 8'(MAX_PAYLOAD);

  phase_t      phase, phase_next;
  logic [31:0] declared_length, declared_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  command_seen, command_seen_next;
  logic [7:0]  running_check, running_check_next;
  logic [7:0]  frame_id_seen, frame_id_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SOF;
      declared_length <= '0;
      payload_count   <= '0;
      command_seen    <= '0;
      running_check   <= '0;
      frame_id_seen   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      payload_count   <= payload_count_next;
      command_seen    <= command_seen_next;
      running_check   <= running_check_next;
      frame_id_seen   <= frame_id_seen_next;
    end
  end

  always_comb begin
    logic [7:0] ch;
    logic [7:0] check_base;
    logic [1:0] status;
    logic [7:0] count_inc;
    ch                   = item.data_byte;
    check_base           = running_check;
    status               = ST_NONE;
    count_inc            = payload_count + 8'd1;
    phase_next           = phase;
    declared_length_next = declared_length;
    payload_count_next   = payload_count;
    command_seen_next    = command_seen;
    frame_id_seen_next   = frame_id_seen;
    res.payload_valid    = 1'b0;
    res.payload_byte     = '0;
    res.payload_index    = '0;

    if (item.operation == OP_CLEAR) begin
      phase_next           = PH_SOF;
      declared_length_next = '0;
      payload_count_next   = '0;
      command_seen_next    = '0;
      frame_id_seen_next   = '0;
      running_check_next   = '0;
    end else begin
      case (phase)
        PH_SOF: begin
          if (ch == start_marker) begin
            phase_next         = PH_LEN;
            payload_count_next = '0;
          end
        end
        PH_LEN: begin
          declared_length_next = {24'h0, ch};
          check_base           = '0;
          phase_next           = PH_ID;
        end
        PH_ID: begin
          frame_id_seen_next = ch;
          phase_next         = PH_CMD;
        end
        PH_CMD: begin
          command_seen_next = ch;
          if (declared_length == 32'h0) begin
            phase_next = PH_FCS;
          end else if (declared_length == {24'h0, EXT_LEN_CODE}) begin
            phase_next = PH_XL1;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_XL1: begin
          declared_length_next = {24'h0, ch};
          phase_next           = PH_XL2;
        end
        PH_XL2: begin
          declared_length_next = declared_length + {16'h0, ch, 8'h0};
          phase_next           = PH_XL3;
        end
        PH_XL3: begin
          declared_length_next = declared_length + {8'h0, ch, 16'h0};
          phase_next           = PH_XL4;
        end
        PH_XL4: begin
          declared_length_next = declared_length + {ch, 24'h0};
          phase_next = (declared_length_next != 32'h0) ? PH_DATA : PH_FCS;
        end
        PH_DATA: begin
          if (payload_count >= MaxCount) begin
            phase_next = PH_SOF;
            status     = ST_OVERSIZE;
          end else begin
            res.payload_valid  = 1'b1;
            res.payload_byte   = ch;
            res.payload_index  = payload_count;
            payload_count_next = count_inc;
            if ({24'h0, count_inc} == declared_length) begin
              phase_next = PH_FCS;
            end
          end
        end
        PH_FCS: begin
          if (running_check == ch && frame_id_seen == expected_frame_id) begin
            status = ST_ACCEPT;
          end else begin
            status = ST_REJECT;
          end
          phase_next = PH_SOF;
        end
        default: begin
          phase_next = PH_SOF;
        end
      endcase
      running_check_next = check_base ^ ch;
    end

    res.status         = status;
    res.command        = command_seen_next;
    res.frame_length   = declared_length_next;
    res.chunk_accepted = item.chunk_end && (status == ST_ACCEPT);
  end

endmodule

`default_nettype wire

>>> rtl/boot_frame_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial deframer for bootloader response frames.
// req carries one item per received byte: operation (receive or clear),
// data_byte and chunk_end. rsp returns exactly one result per item, in
// order: frame status, current command, the payload byte with its index
// when the byte is payload, the declared length and chunk_accepted.
// Items pass an input register and then the parser into the result
// register, which loads from the parser when the input register holds an
// item and the result register is empty or being read.
// One item per cycle is sustained while rsp is ready; the only loop is
// the per-byte parser state update, one step per cycle.
// If rsp stalls, the result register holds and the input register still
// takes one more item; req.ready drops only when both are full.
// The config port (cfg_we, cfg_index, cfg_data) sets the start marker and
// expected frame id; write only while the block is idle.
// Synchronous reset empties both registers, returns the parser to waiting
// for a start byte and restores the default marker and frame id.

module boot_frame_receiver_top #(
  parameter int MAX_PAYLOAD = 255
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              cfg_we,
  input wire logic [bfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [bfr_pkg::CFG_DATA_W-1:0]    cfg_data,
  bfr_in_if.sink                                req,
  bfr_out_if.source                             rsp
);
  import bfr_pkg::*;

  logic [7:0] start_marker;
  logic [7:0] expected_frame_id;

  logic       in_valid;
  in_item_t   in_item;
  logic       out_valid;
  result_t    out_res;
  result_t    res;
  logic       advance;
  logic       step;

  assign advance   = !out_valid || rsp.ready;
  assign step      = in_valid && advance;
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker      <= START_MARKER_RST;
      expected_frame_id <= FRAME_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MARKER: start_marker      <= cfg_data;
        REG_FRAME_ID:     expected_frame_id <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item.operation <= req.operation;
      in_item.data_byte <= req.data_byte;
      in_item.chunk_end <= req.chunk_end;
    end
  end

  bfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .item              (in_item),
    .start_marker      (start_marker),
    .expected_frame_id (expected_frame_id),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_res.status;
  assign rsp.command        = out_res.command;
  assign rsp.payload_valid  = out_res.payload_valid;
  assign rsp.payload_byte   = out_res.payload_byte;
  assign rsp.payload_index  = out_res.payload_index;
  assign rsp.frame_length   = out_res.frame_length;
  assign rsp.chunk_accepted = out_res.chunk_accepted;

endmodule

`default_nettype wire
